[rtl/sfr_pkg.sv]
// shared types, codes and reset values for the stuffed frame receiver
package sfr_pkg;

   localparam int DATA_W = 8;
   localparam int LEN_W  = 11;
   localparam int IDX_W  = 3;

   localparam logic [DATA_W-1:0] CRC_INIT = 8'hff;

   typedef enum logic [2:0] {
      ST_CONTINUE   = 3'd0,
      ST_PACKET_OK  = 3'd1,
      ST_CRC_ERROR  = 3'd2,
      ST_BAD_ESCAPE = 3'd3,
      ST_OVERFLOW   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_FRAME = 2'd1,
      PH_ESC   = 2'd2
   } phase_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_START_BYTE     = 3'd0,
      CSR_ESCAPE_BYTE    = 3'd1,
      CSR_ESC_START_CODE = 3'd2,
      CSR_ESC_ESC_CODE   = 3'd3,
      CSR_CRC_POLY       = 3'd4,
      CSR_MAX_FRAME_LEN  = 3'd5
   } csr_addr_type;

   localparam logic [DATA_W-1:0] RST_START_BYTE     = 8'hac;
   localparam logic [DATA_W-1:0] RST_ESCAPE_BYTE    = 8'had;
   localparam logic [DATA_W-1:0] RST_ESC_START_CODE = 8'hae;
   localparam logic [DATA_W-1:0] RST_ESC_ESC_CODE   = 8'haf;
   localparam logic [DATA_W-1:0] RST_CRC_POLY       = 8'h31;
   localparam logic [LEN_W-1:0]  RST_MAX_FRAME_LEN  = 11'd1024;

   typedef struct packed {
      logic [DATA_W-1:0] start_byte;
      logic [DATA_W-1:0] escape_byte;
      logic [DATA_W-1:0] esc_start_code;
      logic [DATA_W-1:0] esc_esc_code;
      logic [DATA_W-1:0] crc_poly;
      logic [LEN_W-1:0]  max_frame_len;
   } cfg_type;

   typedef struct packed {
      status_type        status;
      logic              data_valid;
      logic [DATA_W-1:0] data_byte;
      logic [LEN_W-1:0]  frame_length;
   } rsp_type;

endpackage

[rtl/sfr_csr.sv]
// configuration registers of the stuffed frame receiver
module sfr_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [sfr_pkg::IDX_W-1:0] csr_index,
   input  logic [sfr_pkg::LEN_W-1:0] csr_data,
   output sfr_pkg::cfg_type         cfg
);
   import sfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE:     cfg_in.start_byte     = csr_data[DATA_W-1:0];
            CSR_ESCAPE_BYTE:    cfg_in.escape_byte    = csr_data[DATA_W-1:0];
            CSR_ESC_START_CODE: cfg_in.esc_start_code = csr_data[DATA_W-1:0];
            CSR_ESC_ESC_CODE:   cfg_in.esc_esc_code   = csr_data[DATA_W-1:0];
            CSR_CRC_POLY:       cfg_in.crc_poly       = csr_data[DATA_W-1:0];
            CSR_MAX_FRAME_LEN:  cfg_in.max_frame_len  = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte     <= RST_START_BYTE;
         cfg_ff.escape_byte    <= RST_ESCAPE_BYTE;
         cfg_ff.esc_start_code <= RST_ESC_START_CODE;
         cfg_ff.esc_esc_code   <= RST_ESC_ESC_CODE;
         cfg_ff.crc_poly       <= RST_CRC_POLY;
         cfg_ff.max_frame_len  <= RST_MAX_FRAME_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/sfr_crc8.sv]
// msb-first crc-8 update of one byte with a programmable polynomial
module sfr_crc8 (
   input  logic [sfr_pkg::DATA_W-1:0] crc_prev,
   input  logic [sfr_pkg::DATA_W-1:0] data,
   input  logic [sfr_pkg::DATA_W-1:0] poly,
   output logic [sfr_pkg::DATA_W-1:0] crc_next
);
   import sfr_pkg::*;

   always_comb begin
      logic [DATA_W-1:0] r;
      r = crc_prev ^ data;
      for (int i = 0; i < DATA_W; i++) begin
         if (r[DATA_W-1]) begin
            r = {r[DATA_W-2:0], 1'b0} ^ poly;
         end else begin
            r = {r[DATA_W-2:0], 1'b0};
         end
      end
      crc_next = r;
   end

endmodule

[rtl/sfr_deframe.sv]
// unstuffing state machine, frame counter, crc register and result register
module sfr_deframe #(
   parameter int MAX_LEN = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [sfr_pkg::DATA_W-1:0] rx_byte,
   input  sfr_pkg::cfg_type           cfg,
   output sfr_pkg::rsp_type           rsp
);
   import sfr_pkg::*;

   // the length register can never exceed the 11-bit configured capacity
   localparam int LEN_MAX = (2 ** LEN_W) - 1;
   localparam int CAP_INT = (MAX_LEN < LEN_MAX) ? MAX_LEN : LEN_MAX;
   localparam int CNT_W   = $clog2(CAP_INT + 1);
   localparam logic [LEN_W-1:0] CAP_LIMIT = LEN_W'(CAP_INT);

   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] crc_ff, crc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   rsp_type           rsp_ff, rsp_in;

   logic [DATA_W-1:0] crc_base;
   logic [CNT_W-1:0]  cnt_base;
   logic [DATA_W-1:0] byte_sel;
   logic [DATA_W-1:0] crc_upd;
   logic [LEN_W-1:0]  cap;
   logic              in_frame;
   logic              take;

   sfr_crc8 u_crc8 (
      .crc_prev (crc_base),
      .data     (byte_sel),
      .poly     (cfg.crc_poly),
      .crc_next (crc_upd)
   );

   assign cap = (cfg.max_frame_len > CAP_LIMIT) ? CAP_LIMIT : cfg.max_frame_len;

   always_comb begin
      // idle (and the unused code) starts a fresh frame before handling the byte
      in_frame = (phase_ff != PH_ESC);
      if (phase_ff == PH_FRAME || phase_ff == PH_ESC) begin
         crc_base = crc_ff;
         cnt_base = cnt_ff;
      end else begin
         crc_base = CRC_INIT;
         cnt_base = '0;
      end

      phase_in          = PH_FRAME;
      take              = 1'b0;
      byte_sel          = rx_byte;
      rsp_in.status     = ST_CONTINUE;
      rsp_in.data_valid = 1'b0;
      rsp_in.data_byte  = '0;

      if (in_frame) begin
         priority if (rx_byte == cfg.start_byte) begin
            if (cnt_base != '0) begin
               rsp_in.status = (crc_base != '0) ? ST_CRC_ERROR : ST_PACKET_OK;
               phase_in      = PH_IDLE;
            end
         end else if (rx_byte == cfg.escape_byte) begin
            phase_in = PH_ESC;
         end else begin
            take = 1'b1;
         end
      end else begin
         priority if (rx_byte == cfg.esc_start_code) begin
            byte_sel = cfg.start_byte;
            take     = 1'b1;
         end else if (rx_byte == cfg.esc_esc_code) begin
            byte_sel = cfg.escape_byte;
            take     = 1'b1;
         end else begin
            rsp_in.status = ST_BAD_ESCAPE;
            phase_in      = PH_IDLE;
         end
      end

      crc_in = crc_base;
      cnt_in = cnt_base;
      if (take) begin
         if (LEN_W'(cnt_base) >= cap) begin
            rsp_in.status = ST_OVERFLOW;
            phase_in      = PH_IDLE;
         end else begin
            cnt_in            = cnt_base + CNT_W'(1);
            crc_in            = crc_upd;
            rsp_in.data_valid = 1'b1;
            rsp_in.data_byte  = byte_sel;
            phase_in          = PH_FRAME;
         end
      end
      rsp_in.frame_length = LEN_W'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         crc_ff   <= CRC_INIT;
         cnt_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[rtl/stuffed_frame_receiver_crc8.sv]
// top level of the stuffed frame receiver with crc-8 check
//
//   channel   direction  ports                                     handshake
//   req       in         req_rx_byte                               req_valid / req_stall
//   rsp       out        rsp_status, rsp_data_valid, rsp_data_byte,
//                        rsp_frame_length                          rsp_valid / rsp_stall
//   csr       in         csr_index, csr_data                       csr_we
//
// one byte per cycle sustained while rsp_stall is low; a byte goes from its transfer in
// to its result through the input register, then the unstuffing logic into the result register
// synchronous reset returns to idle with crc 0xff and length 0; no clearing pass
// rsp_stall holds the result register; the input register keeps taking bytes
// until it is full, then req_stall rises in the same cycle
module stuffed_frame_receiver_crc8 #(
   parameter int MAX_LEN = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [sfr_pkg::DATA_W-1:0] req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_data_valid,
   output logic [sfr_pkg::DATA_W-1:0] rsp_data_byte,
   output logic [sfr_pkg::LEN_W-1:0]  rsp_frame_length,
   input  logic                       csr_we,
   input  logic [sfr_pkg::IDX_W-1:0]  csr_index,
   input  logic [sfr_pkg::LEN_W-1:0]  csr_data
);
   import sfr_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   logic              out_free;
   logic              fire;
   logic              req_take;
   cfg_type           cfg;
   rsp_type           rsp;

   sfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfr_deframe #(
      .MAX_LEN (MAX_LEN)
   ) u_deframe (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .rsp     (rsp)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = rsp.status;
   assign rsp_data_valid   = rsp.data_valid;
   assign rsp_data_byte    = rsp.data_byte;
   assign rsp_frame_length = rsp.frame_length;

endmodule
